@@ hdl/fle_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, request codes and arithmetic unit types for the facility cost evaluator.
package fle_pkg;

	// Fixed field widths of the request, result and configuration transactions.
	localparam int REQ_TYPE_W = 2;
	localparam int INDEX_W    = 7;
	localparam int COST_IN_W  = 32;
	localparam int TOTAL_W    = 48;
	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// Request codes.
	localparam logic [REQ_TYPE_W-1:0] REQ_OPEN_COST   = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_ASSIGN_COST = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_OPEN_BIT    = 2'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_EVALUATE    = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FACILITIES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CUSTOMERS  = 1'd1;

	// Operands of the shared add and compare unit.
	typedef struct packed {
		logic [TOTAL_W-1:0] a;
		logic [TOTAL_W-1:0] b;
		logic               sub;
	} alu_req_t;

	// Results of the shared add and compare unit.
	typedef struct packed {
		logic [TOTAL_W-1:0] value;
		logic               carry;
	} alu_res_t;

endpackage

@@ hdl/fle_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: table writes and evaluate requests.
interface fle_req_if import fle_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [INDEX_W-1:0]    facility_index;
	logic [INDEX_W-1:0]    customer_index;
	logic [COST_IN_W-1:0]  cost_value;
	logic                  open_flag;

	modport source (
		output valid, req_type, facility_index, customer_index, cost_value, open_flag,
		input  ready
	);
	modport sink (
		input  valid, req_type, facility_index, customer_index, cost_value, open_flag,
		output ready
	);
endinterface

@@ hdl/fle_res_if.sv @@
`timescale 1ns / 1ps
// Result channel: one evaluated total per evaluate request.
interface fle_res_if import fle_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] total_cost;
	logic               none_open;
	logic               saturated;

	modport source (
		output valid, total_cost, none_open, saturated,
		input  ready
	);
	modport sink (
		input  valid, total_cost, none_open, saturated,
		output ready
	);
endinterface

@@ hdl/fle_alu.sv @@
`timescale 1ns / 1ps
// Shared adder: saturating accumulate or magnitude compare through one carry chain.
module fle_alu import fle_pkg::*; (
	input  alu_req_t op,
	output alu_res_t res
);

	logic [TOTAL_W:0] sum;

	// Subtract mode inverts b and injects a carry, so carry out means a >= b.
	always_comb begin
		sum = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + (TOTAL_W + 1)'(op.sub);
		res.carry = sum[TOTAL_W];
		if (!op.sub && sum[TOTAL_W]) begin
			res.value = TOTAL_MAX;
		end else begin
			res.value = sum[TOTAL_W-1:0];
		end
	end

endmodule

@@ hdl/facility_location_cost_eval_unit.sv @@
`timescale 1ns / 1ps
// Facility location cost evaluator: holds cost tables and sums the objective on request.
//
// Write requests (opening cost, assignment cost, open bit) are taken only in the idle state and
// return nothing. An evaluate request returns one result after a scan over nf facilities and
// nc customers, where nf and nc are the facility and customer counts in use (clipped to the
// table sizes); with no facility in use it goes straight to the result. The scan is paced by the
// single read port of the assignment cost memory, one entry per cycle, and by the one shared adder,
// which takes each opening cost, each compare for the running minimum and an extra add per customer
// to fold that minimum into the total. No new request is taken during an evaluation. The cost
// memories are not cleared: an entry read before it was written gives an undefined total. The
// open bits reset to closed. Writes with an index beyond a table are dropped.
module facility_location_cost_eval_unit import fle_pkg::*; #(
	parameter int MAX_FACILITIES = 128,
	parameter int MAX_CUSTOMERS  = 128,
	parameter int COST_BITS      = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	fle_req_if.sink              req,
	fle_res_if.source            res
);

	localparam int FAC_W = $clog2(MAX_FACILITIES);
	localparam int CUS_W = (MAX_CUSTOMERS > 1) ? $clog2(MAX_CUSTOMERS) : 1;
	localparam int CMP_W = ((FAC_W > CUS_W) ? FAC_W : CUS_W) + CFG_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPEN_SCAN,
		ST_CUST_SCAN,
		ST_CUST_ADD,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_OPEN,
		OP_MIN,
		OP_ADD
	} op_t;

	state_t state_q;
	logic [CFG_W-1:0] num_fac_q;
	logic [CFG_W-1:0] num_cus_q;
	logic [CFG_W-1:0] nf_q;
	logic [CFG_W-1:0] nc_q;
	logic [FAC_W-1:0] fac_q;
	logic [CUS_W-1:0] cus_q;

	logic [COST_BITS-1:0] open_cost_mem [MAX_FACILITIES];
	logic [COST_BITS-1:0] asg_cost_mem [MAX_CUSTOMERS][MAX_FACILITIES];
	logic [MAX_FACILITIES-1:0] open_q;

	op_t                  op_s1;
	logic [COST_BITS-1:0] open_cost_s1;
	logic [COST_BITS-1:0] asg_cost_s1;
	logic                 open_s1;

	logic [TOTAL_W-1:0]   total_q;
	logic [COST_BITS-1:0] best_q;
	logic                 have_q;
	logic                 any_q;
	logic                 sat_q;

	logic                 res_valid_q;
	logic [TOTAL_W-1:0]   res_total_q;
	logic                 res_none_q;
	logic                 res_sat_q;

	logic                 req_fire;
	logic                 fac_ok;
	logic                 cus_ok;
	logic [FAC_W-1:0]     wr_fac;
	logic [CUS_W-1:0]     wr_cus;
	logic [COST_BITS-1:0] wr_cost;
	logic                 fac_last;
	logic                 cus_last;
	logic [CFG_W-1:0]     nf_clip;
	logic [CFG_W-1:0]     nc_clip;
	logic [COST_BITS-1:0] cost_s1;
	alu_req_t             alu_op;
	alu_res_t             alu_out;

	// Handshake and request decode.
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign fac_ok    = 32'(req.facility_index) < MAX_FACILITIES;
	assign cus_ok    = 32'(req.customer_index) < MAX_CUSTOMERS;
	assign wr_fac    = FAC_W'(req.facility_index);
	assign wr_cus    = CUS_W'(req.customer_index);
	assign wr_cost   = COST_BITS'(TOTAL_W'(req.cost_value));

	// Counts in use, clipped to the table sizes.
	assign nf_clip  = (32'(num_fac_q) > MAX_FACILITIES) ? CFG_W'(MAX_FACILITIES) : num_fac_q;
	assign nc_clip  = (32'(num_cus_q) > MAX_CUSTOMERS) ? CFG_W'(MAX_CUSTOMERS) : num_cus_q;
	assign fac_last = (CMP_W'(fac_q) + CMP_W'(1)) == CMP_W'(nf_q);
	assign cus_last = (CMP_W'(cus_q) + CMP_W'(1)) == CMP_W'(nc_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_fac_q <= CFG_W'(1);
			num_cus_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_FACILITIES: num_fac_q <= cfg_data;
				REG_NUM_CUSTOMERS:  num_cus_q <= cfg_data;
			endcase
		end
	end

	// Cost memories: one write port from the request channel, registered reads for the scan.
	always_ff @(posedge clk) begin
		if (req_fire && req.req_type == REQ_OPEN_COST && fac_ok) begin
			open_cost_mem[wr_fac] <= wr_cost;
		end
		open_cost_s1 <= open_cost_mem[fac_q];
	end

	always_ff @(posedge clk) begin
		if (req_fire && req.req_type == REQ_ASSIGN_COST && fac_ok && cus_ok) begin
			asg_cost_mem[wr_cus][wr_fac] <= wr_cost;
		end
		asg_cost_s1 <= asg_cost_mem[cus_q][fac_q];
	end

	// Open bits reset to closed and are read in step with the cost memories.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= '0;
			open_s1 <= 1'b0;
		end else begin
			if (req_fire && req.req_type == REQ_OPEN_BIT && fac_ok) begin
				open_q[wr_fac] <= req.open_flag;
			end
			open_s1 <= open_q[fac_q];
		end
	end

	// Operand selection for the shared unit.
	assign cost_s1 = (op_s1 == OP_OPEN) ? open_cost_s1 : asg_cost_s1;

	always_comb begin
		unique case (op_s1)
			OP_MIN: begin
				alu_op.a   = TOTAL_W'(cost_s1);
				alu_op.b   = TOTAL_W'(best_q);
				alu_op.sub = 1'b1;
			end
			OP_ADD: begin
				alu_op.a   = total_q;
				alu_op.b   = TOTAL_W'(best_q);
				alu_op.sub = 1'b0;
			end
			default: begin
				alu_op.a   = total_q;
				alu_op.b   = TOTAL_W'(cost_s1);
				alu_op.sub = 1'b0;
			end
		endcase
	end

	fle_alu u_alu (
		.op  (alu_op),
		.res (alu_out)
	);

	// Sequencer, accumulators and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_s1       <= OP_NONE;
			fac_q       <= '0;
			cus_q       <= '0;
			nf_q        <= '0;
			nc_q        <= '0;
			any_q       <= 1'b0;
			sat_q       <= 1'b0;
			have_q      <= 1'b0;
			total_q     <= '0;
			best_q      <= '0;
			res_valid_q <= 1'b0;
			res_total_q <= '0;
			res_none_q  <= 1'b0;
			res_sat_q   <= 1'b0;
		end else begin
			op_s1 <= OP_NONE;
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end

			// Execute the operation held in the read stage.
			unique case (op_s1)
				OP_OPEN: begin
					if (open_s1) begin
						any_q   <= 1'b1;
						total_q <= alu_out.value;
						if (alu_out.carry) sat_q <= 1'b1;
					end
				end
				OP_MIN: begin
					if (open_s1 && (!have_q || !alu_out.carry)) begin
						best_q <= cost_s1;
						have_q <= 1'b1;
					end
				end
				OP_ADD: begin
					total_q <= alu_out.value;
					have_q  <= 1'b0;
					if (alu_out.carry) sat_q <= 1'b1;
				end
				OP_NONE: ;
			endcase

			// Issue the next read and operation.
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && req.req_type == REQ_EVALUATE) begin
						nf_q    <= nf_clip;
						nc_q    <= nc_clip;
						fac_q   <= '0;
						cus_q   <= '0;
						total_q <= '0;
						any_q   <= 1'b0;
						sat_q   <= 1'b0;
						have_q  <= 1'b0;
						state_q <= (nf_clip == '0) ? ST_FINISH : ST_OPEN_SCAN;
					end
				end
				ST_OPEN_SCAN: begin
					op_s1 <= OP_OPEN;
					if (fac_last) begin
						fac_q   <= '0;
						state_q <= (nc_q == '0) ? ST_DRAIN : ST_CUST_SCAN;
					end else begin
						fac_q <= fac_q + FAC_W'(1);
					end
				end
				ST_CUST_SCAN: begin
					op_s1 <= OP_MIN;
					if (fac_last) begin
						fac_q   <= '0;
						state_q <= ST_CUST_ADD;
					end else begin
						fac_q <= fac_q + FAC_W'(1);
					end
				end
				ST_CUST_ADD: begin
					op_s1 <= OP_ADD;
					if (cus_last) begin
						state_q <= ST_DRAIN;
					end else begin
						cus_q   <= cus_q + CUS_W'(1);
						state_q <= ST_CUST_SCAN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						res_total_q <= any_q ? total_q : TOTAL_MAX;
						res_none_q  <= !any_q;
						res_sat_q   <= !any_q || sat_q;
						fac_q       <= '0;
						cus_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid      = res_valid_q;
	assign res.total_cost = res_total_q;
	assign res.none_open  = res_none_q;
	assign res.saturated  = res_sat_q;

	// An accepted evaluate holds off the request channel on the next cycle.
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.req_type == REQ_EVALUATE) |=> !req.ready)
		else $error("request accepted during an evaluation");

	// The result is captured only after the read stage has emptied.
	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (op_s1 == OP_NONE))
		else $error("result captured with an operation still in flight");

	// With no facility open the total is the saturated maximum.
	a_none_open_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_none_q) |-> (res_sat_q && res_total_q == TOTAL_MAX))
		else $error("none_open result without saturated maximum");

	// The running minimum is consumed by the end of each customer.
	a_have_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(op_s1 == OP_ADD) |=> !have_q)
		else $error("minimum flag survived the customer add");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the facility location cost evaluator: table writes, evaluations and checks.
module tb_top;
	import fle_pkg::*;

	localparam int FAC_SLOTS      = 128;
	localparam int CUS_SLOTS      = 128;
	localparam int WRITE_SETTLE   = 4;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 80000;
	localparam int LONG_HOLD      = 200;
	localparam int RANDOM_EVALS   = 25;
	localparam int PRESSURE_ROUND = 6;
	// Costs are written for the first few facilities and customers and for the last facility
	// slot; only those facilities are ever opened and only those customers are ever in use.
	localparam int REGION_FACS    = 4;
	localparam int REGION_CUS     = 4;
	localparam int SPARE_FAC      = 127;

	// One request transaction as the block sees it.
	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [INDEX_W-1:0]    facility_index;
		logic [INDEX_W-1:0]    customer_index;
		logic [COST_IN_W-1:0]  cost_value;
		logic                  open_flag;
	} request_t;

	// One result transaction: the objective value and its flags.
	typedef struct packed {
		logic [TOTAL_W-1:0] total_cost;
		logic               none_open;
		logic               saturated;
	} objective_t;

	// One line of the directed table: an optional register write, the request, and an
	// optional expectation typed in by hand.
	typedef struct {
		bit                   cfg_en;
		logic [CFG_IDX_W-1:0] cfg_idx;
		logic [CFG_W-1:0]     cfg_val;
		request_t             rq;
		bit                   typed_en;
		objective_t           typed_exp;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	fle_req_if req_ch ();
	fle_res_if res_ch ();

	facility_location_cost_eval_unit #(
		.MAX_FACILITIES(FAC_SLOTS),
		.MAX_CUSTOMERS (CUS_SLOTS),
		.COST_BITS     (COST_IN_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.res      (res_ch)
	);

	// Mirror of the block's tables and registers.
	logic [COST_IN_W-1:0] open_cost_tab [FAC_SLOTS];
	logic [COST_IN_W-1:0] assign_cost_tab [CUS_SLOTS][FAC_SLOTS];
	bit                   open_bits [FAC_SLOTS];
	logic [CFG_W-1:0]     fac_in_use;
	logic [CFG_W-1:0]     cus_in_use;

	// Objectives still owed by the block, oldest first.
	objective_t pending_totals [$];

	bit         given_exp_en;
	objective_t given_exp;
	int         fail_count;
	int         stall_cycles;
	bit         gaps_on;
	bit         long_hold_req;
	bit         accepted_any;
	objective_t seen_total;
	objective_t want_total;
	request_t   seen_req;

	always #6 clk = ~clk;

	// Objective of the current tables: open facility costs plus each customer's cheapest
	// open facility, saturating at the top of the total's range.
	function automatic objective_t predict_objective();
		int                   nf;
		int                   nc;
		logic [TOTAL_W:0]     sum;
		logic [COST_IN_W-1:0] least;
		bit                   any_open;
		bit                   have;
		bit                   clipped;
		nf = (fac_in_use > FAC_SLOTS) ? FAC_SLOTS : int'(fac_in_use);
		nc = (cus_in_use > CUS_SLOTS) ? CUS_SLOTS : int'(cus_in_use);
		sum = '0;
		clipped = 1'b0;
		any_open = 1'b0;
		for (int j = 0; j < nf; j++) begin
			if (open_bits[j]) begin
				any_open = 1'b1;
				sum = sum + open_cost_tab[j];
				if (sum > TOTAL_MAX) begin
					sum = TOTAL_MAX;
					clipped = 1'b1;
				end
			end
		end
		if (!any_open)
			return '{TOTAL_MAX, 1'b1, 1'b1};
		for (int i = 0; i < nc; i++) begin
			have = 1'b0;
			least = '0;
			for (int j = 0; j < nf; j++) begin
				if (open_bits[j] && (!have || assign_cost_tab[i][j] < least)) begin
					least = assign_cost_tab[i][j];
					have = 1'b1;
				end
			end
			sum = sum + least;
			if (sum > TOTAL_MAX) begin
				sum = TOTAL_MAX;
				clipped = 1'b1;
			end
		end
		return '{sum[TOTAL_W-1:0], 1'b0, clipped};
	endfunction

	function automatic request_t make_request(logic [REQ_TYPE_W-1:0] kind, int fac, int cus,
			logic [COST_IN_W-1:0] cost, bit flag);
		request_t r;
		r.req_type = kind;
		r.facility_index = INDEX_W'(fac);
		r.customer_index = INDEX_W'(cus);
		r.cost_value = cost;
		r.open_flag = flag;
		return r;
	endfunction

	function automatic stim_row_t stim_row(bit cfg_en, logic [CFG_IDX_W-1:0] cfg_idx,
			logic [CFG_W-1:0] cfg_val, logic [REQ_TYPE_W-1:0] kind, int fac, int cus,
			logic [COST_IN_W-1:0] cost, bit flag, bit typed_en, logic [TOTAL_W-1:0] exp_total,
			bit exp_none, bit exp_sat);
		stim_row_t r;
		r.cfg_en = cfg_en;
		r.cfg_idx = cfg_idx;
		r.cfg_val = cfg_val;
		r.rq = make_request(kind, fac, cus, cost, flag);
		r.typed_en = typed_en;
		r.typed_exp = '{exp_total, exp_none, exp_sat};
		return r;
	endfunction

	function automatic int draw_gap();
		return gaps_on ? $urandom_range(0, 7) : 0;
	endfunction

	// Costs lean on the extremes of the field.
	function automatic logic [COST_IN_W-1:0] draw_cost();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return COST_IN_W'($urandom_range(0, 255));
			default: return COST_IN_W'($urandom());
		endcase
	endfunction

	// Counts are mostly small so that evaluations stay short; a few go past the table size.
	function automatic logic [CFG_W-1:0] draw_count();
		case ($urandom_range(0, 9))
			7, 8: return CFG_W'($urandom_range(9, 40));
			9: return CFG_W'($urandom_range(41, 255));
			default: return CFG_W'($urandom_range(0, 8));
		endcase
	endfunction

	// Customer counts stay within the customers whose costs are written.
	function automatic logic [CFG_W-1:0] draw_cus_count();
		return CFG_W'($urandom_range(0, REGION_CUS));
	endfunction

	// A facility whose costs are all written: one of the first few, or the last slot.
	function automatic int draw_region_fac();
		if ($urandom_range(0, 4) == 0)
			return SPARE_FAC;
		return $urandom_range(0, REGION_FACS - 1);
	endfunction

	// Table writes stay on written entries, except a few cost writes to facilities never opened.
	function automatic request_t random_write();
		logic [REQ_TYPE_W-1:0] kind;
		int                    fac;
		int                    cus;
		kind = REQ_TYPE_W'($urandom_range(REQ_OPEN_COST, REQ_OPEN_BIT));
		fac = draw_region_fac();
		cus = $urandom_range(0, REGION_CUS - 1);
		if (kind != REQ_OPEN_BIT && $urandom_range(0, 9) == 0) begin
			fac = $urandom_range(REGION_FACS, SPARE_FAC - 1);
			cus = $urandom_range(0, CUS_SLOTS - 1);
		end
		return make_request(kind, fac, cus, draw_cost(), 1'($urandom));
	endfunction

	function automatic request_t random_eval();
		return make_request(REQ_EVALUATE, $urandom_range(0, FAC_SLOTS - 1),
			$urandom_range(0, CUS_SLOTS - 1), COST_IN_W'($urandom()), 1'($urandom));
	endfunction

	// Offer one request after a random gap and hold it until the block takes it.
	task automatic send_request(request_t r, bit typed_en, objective_t typed_exp);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.req_type;
		req_ch.facility_index <= r.facility_index;
		req_ch.customer_index <= r.customer_index;
		req_ch.cost_value <= r.cost_value;
		req_ch.open_flag <= r.open_flag;
		given_exp_en <= typed_en;
		given_exp <= typed_exp;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	// Let every owed result come back and the last write finish before touching a register.
	task automatic settle_block();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_totals.size() != 0) @(negedge clk);
		repeat (WRITE_SETTLE) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Monitor: check results, track the tables and registers, count idle cycles.
	always @(posedge clk) begin
		accepted_any = 1'b0;
		// A result transaction is compared with the oldest owed objective.
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			accepted_any = 1'b1;
			seen_total = '{res_ch.total_cost, res_ch.none_open, res_ch.saturated};
			if (pending_totals.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing owed, expected none, actual %h %b %b", $time,
					seen_total.total_cost, seen_total.none_open, seen_total.saturated);
			end else begin
				want_total = pending_totals.pop_front();
				if (seen_total.total_cost !== want_total.total_cost) begin
					fail_count++;
					$display("%0t: total_cost mismatch, expected %h, actual %h", $time,
						want_total.total_cost, seen_total.total_cost);
				end
				if (seen_total.none_open !== want_total.none_open) begin
					fail_count++;
					$display("%0t: none_open mismatch, expected %b, actual %b", $time,
						want_total.none_open, seen_total.none_open);
				end
				if (seen_total.saturated !== want_total.saturated) begin
					fail_count++;
					$display("%0t: saturated mismatch, expected %b, actual %b", $time,
						want_total.saturated, seen_total.saturated);
				end
			end
		end
		// A request transaction updates a table or owes one objective.
		if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
			accepted_any = 1'b1;
			seen_req = '{req_ch.req_type, req_ch.facility_index, req_ch.customer_index,
				req_ch.cost_value, req_ch.open_flag};
			case (seen_req.req_type)
				REQ_OPEN_COST:
					open_cost_tab[seen_req.facility_index] = seen_req.cost_value;
				REQ_ASSIGN_COST:
					assign_cost_tab[seen_req.customer_index][seen_req.facility_index] =
						seen_req.cost_value;
				REQ_OPEN_BIT:
					open_bits[seen_req.facility_index] = seen_req.open_flag;
				default:
					pending_totals.push_back(given_exp_en ? given_exp : predict_objective());
			endcase
		end
		// Register writes.
		if (cfg_we === 1'b1) begin
			if (cfg_index == REG_NUM_FACILITIES)
				fac_in_use = cfg_data;
			else
				cus_in_use = cfg_data;
		end
		stall_cycles = accepted_any ? 0 : stall_cycles + 1;
	end

	// Watchdog: too long without any transaction.
	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// Result receiver: random hold-offs, and one long one on request.
	initial begin
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_gap();
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end
			@(negedge clk);
			if (hold != 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
		end
	end

	// Stimulus: directed table, fill of the reachable entries, then random rounds.
	initial begin
		stim_row_t dir_rows [$];
		stim_row_t row;
		request_t  rq;
		int        evals_sent;
		int        round_no;
		int        n_writes;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_NUM_FACILITIES;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_OPEN_COST;
		req_ch.facility_index = '0;
		req_ch.customer_index = '0;
		req_ch.cost_value = '0;
		req_ch.open_flag = 1'b0;
		res_ch.ready = 1'b0;
		fac_in_use = 8'd1;
		cus_in_use = 8'd1;
		fail_count = 0;
		stall_cycles = 0;
		gaps_on = 1'b1;
		long_hold_req = 1'b0;
		given_exp_en = 1'b0;
		given_exp = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, starting from the reset counts of one facility and one customer.
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_OPEN_COST, 0, 0, 0, 0,
			0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_ASSIGN_COST, 0, 0, 0, 0,
			0, 0, 0, 0));
		// Every facility is closed after reset.
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_EVALUATE, 0, 0, 0, 0,
			1, TOTAL_MAX, 1, 1));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_OPEN_BIT, 0, 0, 0, 1,
			0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_EVALUATE, 0, 0, 0, 0,
			1, 48'd0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_OPEN_COST, 0, 0,
			32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_ASSIGN_COST, 0, 0,
			32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_EVALUATE, 0, 0, 0, 0,
			1, 48'h1_FFFF_FFFE, 0, 0));
		// Writes past the counts in use are stored but do not count.
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_OPEN_COST, 127, 127,
			32'h0000_0100, 0, 0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_OPEN_BIT, 127, 0, 0, 1,
			0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_ASSIGN_COST, 127, 127,
			32'h5555_5555, 0, 0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_EVALUATE, 127, 127,
			32'hAAAA_AAAA, 1, 0, 0, 0, 0));
		// No customers in use: opening costs alone.
		dir_rows.push_back(stim_row(1, REG_NUM_CUSTOMERS, 0, REQ_EVALUATE, 0, 0, 0, 0,
			1, 48'h0_FFFF_FFFF, 0, 0));
		// No facilities in use counts as none open.
		dir_rows.push_back(stim_row(1, REG_NUM_FACILITIES, 0, REQ_EVALUATE, 0, 0, 0, 0,
			1, TOTAL_MAX, 1, 1));
		// Two facilities with equal assignment costs, then a strictly cheaper one.
		dir_rows.push_back(stim_row(1, REG_NUM_FACILITIES, 2, REQ_OPEN_COST, 1, 0,
			32'h0000_0003, 0, 0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_ASSIGN_COST, 1, 0,
			32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		dir_rows.push_back(stim_row(1, REG_NUM_CUSTOMERS, 1, REQ_OPEN_BIT, 1, 0, 0, 1,
			0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_EVALUATE, 0, 0, 0, 0,
			0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_OPEN_BIT, 0, 0, 0, 0,
			0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_EVALUATE, 0, 0, 0, 0,
			0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_ASSIGN_COST, 1, 0,
			32'h1234_5678, 0, 0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_OPEN_BIT, 0, 0, 0, 1,
			0, 0, 0, 0));
		dir_rows.push_back(stim_row(0, REG_NUM_FACILITIES, 0, REQ_EVALUATE, 0, 0, 0, 0,
			0, 0, 0, 0));

		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			if (row.cfg_en) begin
				settle_block();
				write_register(row.cfg_idx, row.cfg_val);
			end
			send_request(row.rq, row.typed_en, row.typed_exp);
		end

		// Write every cost that the random part can reach, then evaluate with the facility
		// count past the table size.
		settle_block();
		write_register(REG_NUM_FACILITIES, 8'd255);
		write_register(REG_NUM_CUSTOMERS, CFG_W'(REGION_CUS));
		for (int f = 0; f < REGION_FACS; f++) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			send_request(make_request(REQ_OPEN_COST, f, $urandom_range(0, CUS_SLOTS - 1),
				draw_cost(), 1'($urandom)), 1'b0, '0);
		end
		for (int c = 0; c < REGION_CUS; c++) begin
			for (int f = 0; f < REGION_FACS; f++)
				send_request(make_request(REQ_ASSIGN_COST, f, c, draw_cost(), 1'($urandom)),
					1'b0, '0);
			send_request(make_request(REQ_ASSIGN_COST, SPARE_FAC, c, draw_cost(),
				1'($urandom)), 1'b0, '0);
		end
		send_request(random_eval(), 1'b0, '0);

		// Random rounds: now and then new counts, a few table writes or evaluations, then an evaluation.
		evals_sent = 0;
		round_no = 0;
		while (evals_sent < RANDOM_EVALS || round_no <= PRESSURE_ROUND) begin
			if ($urandom_range(0, 3) == 0) begin
				settle_block();
				write_register(REG_NUM_FACILITIES, draw_count());
				write_register(REG_NUM_CUSTOMERS, draw_cus_count());
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			// Once, back-to-back evaluations against a long receiver hold-off.
			if (round_no == PRESSURE_ROUND) begin
				settle_block();
				write_register(REG_NUM_FACILITIES, 8'd4);
				write_register(REG_NUM_CUSTOMERS, 8'd3);
				gaps_on = 1'b0;
				long_hold_req = 1'b1;
				repeat (8)
					send_request(random_eval(), 1'b0, '0);
				evals_sent += 8;
			end
			n_writes = $urandom_range(1, 4);
			repeat (n_writes) begin
				if ($urandom_range(0, 9) == 0) begin
					rq = random_eval();
					evals_sent++;
				end else begin
					rq = random_write();
				end
				send_request(rq, 1'b0, '0);
			end
			send_request(random_eval(), 1'b0, '0);
			evals_sent++;
			round_no++;
		end

		// Drain the owed results and give a stray result time to show up.
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_totals.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
